[rtl/tcgp_pkg.sv]
// ----------------------------------------------------------------------------
// tcgp_pkg
// Shared types, codes and the character remap for the text cursor glyph placer.
// ----------------------------------------------------------------------------
package tcgp_pkg;

    localparam int unsigned COORD_W = 8;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned IDX_W   = 2;

    localparam logic [COORD_W-1:0] COL_STEP = 8'd6;
    localparam logic [COORD_W-1:0] ROW_STEP = 8'd8;

    localparam logic [CODE_W-1:0] CODE_NEWLINE    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_FORM_FEED  = 8'd12;
    localparam logic [CODE_W-1:0] CODE_FIRST_GLYPH = 8'd32;

    localparam logic OP_PUT_CHAR = 1'b0;
    localparam logic OP_MOVE     = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_COLUMN_ORIGIN = 2'd0,
        REG_LAST_COLUMN   = 2'd1,
        REG_ROW_ORIGIN    = 2'd2,
        REG_LAST_ROW      = 2'd3
    } t_reg_idx;

    localparam logic [COORD_W-1:0] RST_COLUMN_ORIGIN = 8'd3;
    localparam logic [COORD_W-1:0] RST_LAST_COLUMN   = 8'd38;
    localparam logic [COORD_W-1:0] RST_ROW_ORIGIN    = 8'd10;
    localparam logic [COORD_W-1:0] RST_LAST_ROW      = 8'd15;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_GLYPH = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef struct packed {
        logic [COORD_W-1:0] column_origin;
        logic [COORD_W-1:0] last_column;
        logic [COORD_W-1:0] row_origin;
        logic [COORD_W-1:0] last_row;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic [COORD_W-1:0] extent_x;
        logic [COORD_W-1:0] extent_y;
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [CODE_W-1:0]  glyph_index;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] clear_width;
        logic [COORD_W-1:0] clear_height;
    } t_result;

    // fold accented high codes onto the base glyph set
    function automatic logic [CODE_W-1:0] remap_code(input logic [CODE_W-1:0] c);
        logic [15:0]       prod;
        logic [4:0]        q;
        logic [CODE_W-1:0] r;
        logic [CODE_W-1:0] v;
        prod = {8'd0, c} * 16'd187;
        q    = prod[15:11];
        r    = c - CODE_W'({3'd0, q} * 8'd11);
        v    = c;
        if (c > 8'd122) begin
            priority if (c < 8'd206) begin
                v = r + 8'd33;
            end else if (c == 8'd206 || c == 8'd209) begin
                v = 8'd61;
            end else if (c == 8'd207 || c == 8'd210) begin
                v = 8'd59;
            end else if (c == 8'd208 || c == 8'd211) begin
                v = 8'd60;
            end else if (c < 8'd216) begin
                v = {7'd47, c[0]};
            end else if (c == 8'd217) begin
                v = 8'd40;
            end else if (c < 8'd220) begin
                v = r + 8'd33;
            end else if (c == 8'd220) begin
                v = 8'd45;
            end else if (c == 8'd222) begin
                v = 8'd47;
            end else if (c == 8'd223) begin
                v = 8'd64;
            end else begin
                v = c;
            end
        end
        return v;
    endfunction

endpackage

[rtl/tcgp_step.sv]
// ----------------------------------------------------------------------------
// tcgp_step
// Next cursor state and result for one transaction.
// ----------------------------------------------------------------------------
module tcgp_step (
    input  logic                        i_op,
    input  logic [tcgp_pkg::CODE_W-1:0]  i_code,
    input  logic [tcgp_pkg::COORD_W-1:0] i_col,
    input  logic [tcgp_pkg::COORD_W-1:0] i_row,
    input  tcgp_pkg::t_cfg               i_cfg,
    input  tcgp_pkg::t_state             i_state,
    output tcgp_pkg::t_state             o_state,
    output tcgp_pkg::t_result            o_result
);

    logic [tcgp_pkg::COORD_W-1:0] w_adv_x;
    logic [tcgp_pkg::COORD_W-1:0] w_dx;
    logic [15:0]                  w_prod;
    logic [5:0]                   w_col_idx;
    logic [tcgp_pkg::COORD_W-1:0] w_wrap_y;
    logic [tcgp_pkg::COORD_W-1:0] w_wrap_x;
    logic [tcgp_pkg::COORD_W-1:0] w_dy;
    logic                         w_line_wrap;

    // column index of the advanced cursor, divide by 6 via reciprocal
    always_comb begin
        w_adv_x     = i_state.cursor_x + tcgp_pkg::COL_STEP;
        w_dx        = w_adv_x - i_cfg.column_origin;
        w_prod      = {8'd0, w_dx} * 16'd171;
        w_col_idx   = w_prod[15:10];
        w_line_wrap = (w_adv_x >= i_cfg.column_origin) &&
                      ({2'd0, w_col_idx} > i_cfg.last_column);
        w_wrap_x    = w_line_wrap ? i_cfg.column_origin : w_adv_x;
        w_wrap_y    = w_line_wrap ? (i_state.cursor_y + tcgp_pkg::ROW_STEP)
                                  : i_state.cursor_y;
        w_dy        = w_wrap_y - i_cfg.row_origin;
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.action = tcgp_pkg::ACT_NONE;
        if (i_op == tcgp_pkg::OP_MOVE) begin
            o_state.cursor_x = i_cfg.column_origin + {i_col[5:0], 2'b00} + {i_col[6:0], 1'b0};
            o_state.cursor_y = i_cfg.row_origin + {i_row[4:0], 3'b000};
        end else if (i_code == tcgp_pkg::CODE_FORM_FEED) begin
            o_result.action       = tcgp_pkg::ACT_CLEAR;
            o_result.clear_width  = i_state.extent_x;
            o_result.clear_height = i_state.extent_y;
            o_state.extent_x      = i_cfg.column_origin;
            o_state.extent_y      = i_cfg.row_origin;
            o_state.cursor_x      = i_cfg.column_origin;
            o_state.cursor_y      = i_cfg.row_origin;
        end else if (i_code == tcgp_pkg::CODE_NEWLINE) begin
            o_state.cursor_y = i_state.cursor_y + tcgp_pkg::ROW_STEP;
            o_state.cursor_x = i_cfg.column_origin;
        end else if (i_code >= tcgp_pkg::CODE_FIRST_GLYPH) begin
            o_result.action      = tcgp_pkg::ACT_GLYPH;
            o_result.glyph_index = tcgp_pkg::remap_code(i_code) - tcgp_pkg::CODE_FIRST_GLYPH;
            o_result.pos_x       = i_state.cursor_x;
            o_result.pos_y       = i_state.cursor_y;
            if (w_adv_x > i_state.extent_x) begin
                o_state.extent_x = w_adv_x;
            end
            if (i_state.cursor_y > i_state.extent_y) begin
                o_state.extent_y = i_state.cursor_y;
            end
            o_state.cursor_x = w_wrap_x;
            o_state.cursor_y = w_wrap_y;
            if ((w_wrap_y >= i_cfg.row_origin) &&
                ({3'd0, w_dy[7:3]} > i_cfg.last_row)) begin
                o_state.cursor_y = i_cfg.row_origin;
            end
        end
    end

endmodule

[rtl/text_cursor_glyph_placer_core.sv]
// ----------------------------------------------------------------------------
// text_cursor_glyph_placer_core
// Text terminal cursor engine: places glyphs, tracks extents, wraps lines/pages.
// ----------------------------------------------------------------------------
// pipeline: input register, then the cursor state and result register
// throughput: one transaction per cycle unless the receiver stalls; the cursor update
//   is one pass of short logic between the input register and the result register
// reset: synchronous active low; clears the pipeline, cursor and extents,
//   and loads the configuration registers with their defaults
module text_cursor_glyph_placer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tcgp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tcgp_pkg::COORD_W-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_opcode,
    input  logic [tcgp_pkg::CODE_W-1:0]  i_char_code,
    input  logic [tcgp_pkg::COORD_W-1:0] i_target_column,
    input  logic [tcgp_pkg::COORD_W-1:0] i_target_row,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_action,
    output logic [tcgp_pkg::CODE_W-1:0]  o_glyph_index,
    output logic [tcgp_pkg::COORD_W-1:0] o_pos_x,
    output logic [tcgp_pkg::COORD_W-1:0] o_pos_y,
    output logic [tcgp_pkg::COORD_W-1:0] o_clear_width,
    output logic [tcgp_pkg::COORD_W-1:0] o_clear_height
);

    tcgp_pkg::t_cfg    r_cfg;
    tcgp_pkg::t_state  r_state;
    tcgp_pkg::t_state  n_state;
    tcgp_pkg::t_result r_result;
    tcgp_pkg::t_result n_result;

    logic                         r_in_valid;
    logic                         r_in_op;
    logic [tcgp_pkg::CODE_W-1:0]  r_in_code;
    logic [tcgp_pkg::COORD_W-1:0] r_in_col;
    logic [tcgp_pkg::COORD_W-1:0] r_in_row;
    logic                         r_out_valid;
    logic                         w_adv;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_origin <= tcgp_pkg::RST_COLUMN_ORIGIN;
            r_cfg.last_column   <= tcgp_pkg::RST_LAST_COLUMN;
            r_cfg.row_origin    <= tcgp_pkg::RST_ROW_ORIGIN;
            r_cfg.last_row      <= tcgp_pkg::RST_LAST_ROW;
        end else if (i_cfg_we) begin
            unique case (tcgp_pkg::t_reg_idx'(i_cfg_idx))
                tcgp_pkg::REG_COLUMN_ORIGIN: r_cfg.column_origin <= i_cfg_data;
                tcgp_pkg::REG_LAST_COLUMN:   r_cfg.last_column   <= i_cfg_data;
                tcgp_pkg::REG_ROW_ORIGIN:    r_cfg.row_origin    <= i_cfg_data;
                tcgp_pkg::REG_LAST_ROW:      r_cfg.last_row      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_valid;
        end
        if (w_adv && i_valid) begin
            r_in_op   <= i_opcode;
            r_in_code <= i_char_code;
            r_in_col  <= i_target_column;
            r_in_row  <= i_target_row;
        end
    end

    tcgp_step u_step (
        .i_op     (r_in_op),
        .i_code   (r_in_code),
        .i_col    (r_in_col),
        .i_row    (r_in_row),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // cursor state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (w_adv && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_action       = r_result.action;
    assign o_glyph_index  = r_result.glyph_index;
    assign o_pos_x        = r_result.pos_x;
    assign o_pos_y        = r_result.pos_y;
    assign o_clear_width  = r_result.clear_width;
    assign o_clear_height = r_result.clear_height;

endmodule

[tb/tcgp_placement_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgp_placement_checker
// Watches both channels of the glyph placer, tracks the layout registers and
// the cursor, predicts the placement for every accepted transaction and
// compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module tcgp_placement_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tcgp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tcgp_pkg::COORD_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_opcode,
    input  logic [tcgp_pkg::CODE_W-1:0]  i_char_code,
    input  logic [tcgp_pkg::COORD_W-1:0] i_target_column,
    input  logic [tcgp_pkg::COORD_W-1:0] i_target_row,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [1:0]                   i_action,
    input  logic [tcgp_pkg::CODE_W-1:0]  i_glyph_index,
    input  logic [tcgp_pkg::COORD_W-1:0] i_pos_x,
    input  logic [tcgp_pkg::COORD_W-1:0] i_pos_y,
    input  logic [tcgp_pkg::COORD_W-1:0] i_clear_width,
    input  logic [tcgp_pkg::COORD_W-1:0] i_clear_height,
    output int                           o_mismatches,
    output int                           o_results_due
);

    tcgp_pkg::t_cfg    layout;
    tcgp_pkg::t_state  pen;
    tcgp_pkg::t_result placements_due[$];

    function automatic logic [tcgp_pkg::CODE_W-1:0] fold_code(
        input logic [tcgp_pkg::CODE_W-1:0] c);
        int v;
        v = int'(c);
        if (v >= 123 && v <= 205) begin
            v = v % 11 + 33;
        end else if (v >= 206 && v <= 211) begin
            v = v % 3 + 59;
        end else if (v >= 212 && v <= 215) begin
            v = v % 2 + 94;
        end else if (v == 217) begin
            v = 40;
        end else if (v >= 216 && v <= 219) begin
            v = v % 11 + 33;
        end else if (v == 220) begin
            v = 45;
        end else if (v == 222) begin
            v = 47;
        end else if (v == 223) begin
            v = 64;
        end
        return v[tcgp_pkg::CODE_W-1:0];
    endfunction

    function automatic tcgp_pkg::t_result place_item(
        input logic                         op,
        input logic [tcgp_pkg::CODE_W-1:0]  code,
        input logic [tcgp_pkg::COORD_W-1:0] col,
        input logic [tcgp_pkg::COORD_W-1:0] row);
        tcgp_pkg::t_result res;
        res = '0;
        if (op == tcgp_pkg::OP_MOVE) begin
            pen.cursor_x = layout.column_origin + tcgp_pkg::COL_STEP * col;
            pen.cursor_y = layout.row_origin + tcgp_pkg::ROW_STEP * row;
        end else if (code == tcgp_pkg::CODE_FORM_FEED) begin
            res.action       = tcgp_pkg::ACT_CLEAR;
            res.clear_width  = pen.extent_x;
            res.clear_height = pen.extent_y;
            pen.extent_x     = layout.column_origin;
            pen.extent_y     = layout.row_origin;
            pen.cursor_x     = layout.column_origin;
            pen.cursor_y     = layout.row_origin;
        end else if (code == tcgp_pkg::CODE_NEWLINE) begin
            pen.cursor_y = pen.cursor_y + tcgp_pkg::ROW_STEP;
            pen.cursor_x = layout.column_origin;
        end else if (code >= tcgp_pkg::CODE_FIRST_GLYPH) begin
            res.action      = tcgp_pkg::ACT_GLYPH;
            res.glyph_index = fold_code(code) - tcgp_pkg::CODE_FIRST_GLYPH;
            res.pos_x       = pen.cursor_x;
            res.pos_y       = pen.cursor_y;
            pen.cursor_x    = pen.cursor_x + tcgp_pkg::COL_STEP;
            if (pen.cursor_x > pen.extent_x) pen.extent_x = pen.cursor_x;
            if (pen.cursor_y > pen.extent_y) pen.extent_y = pen.cursor_y;
            // a cursor left of the origin never wraps
            if (pen.cursor_x >= layout.column_origin &&
                (pen.cursor_x - layout.column_origin) / tcgp_pkg::COL_STEP >
                layout.last_column) begin
                pen.cursor_x = layout.column_origin;
                pen.cursor_y = pen.cursor_y + tcgp_pkg::ROW_STEP;
            end
            if (pen.cursor_y >= layout.row_origin &&
                (pen.cursor_y - layout.row_origin) / tcgp_pkg::ROW_STEP >
                layout.last_row) begin
                pen.cursor_y = layout.row_origin;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        tcgp_pkg::t_result want;
        if (!i_rst_n) begin
            layout = '{tcgp_pkg::RST_COLUMN_ORIGIN, tcgp_pkg::RST_LAST_COLUMN,
                       tcgp_pkg::RST_ROW_ORIGIN, tcgp_pkg::RST_LAST_ROW};
            pen    = '0;
            placements_due.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (tcgp_pkg::t_reg_idx'(i_cfg_idx))
                    tcgp_pkg::REG_COLUMN_ORIGIN: layout.column_origin = i_cfg_data;
                    tcgp_pkg::REG_LAST_COLUMN:   layout.last_column   = i_cfg_data;
                    tcgp_pkg::REG_ROW_ORIGIN:    layout.row_origin    = i_cfg_data;
                    tcgp_pkg::REG_LAST_ROW:      layout.last_row      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (placements_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual action %0d",
                             $time, i_action);
                    o_mismatches++;
                end else begin
                    want = placements_due.pop_front();
                    check_field("action", 8'(want.action), 8'(i_action));
                    check_field("glyph_index", want.glyph_index, i_glyph_index);
                    check_field("pos_x", want.pos_x, i_pos_x);
                    check_field("pos_y", want.pos_y, i_pos_y);
                    check_field("clear_width", want.clear_width, i_clear_width);
                    check_field("clear_height", want.clear_height, i_clear_height);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                placements_due.push_back(place_item(i_opcode, i_char_code,
                                                    i_target_column, i_target_row));
            end
        end
        o_results_due = placements_due.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives character and cursor-move transactions into the glyph placer under
// several layout settings, with random gaps and back-pressure, and reports
// the verdict from the placement checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ITEMS_PER_PHASE = 170;
    localparam int LONG_HOLD       = 60;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [tcgp_pkg::IDX_W-1:0]   i_cfg_idx;
    logic [tcgp_pkg::COORD_W-1:0] i_cfg_data;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_opcode;
    logic [tcgp_pkg::CODE_W-1:0]  i_char_code;
    logic [tcgp_pkg::COORD_W-1:0] i_target_column;
    logic [tcgp_pkg::COORD_W-1:0] i_target_row;
    logic                         o_valid;
    logic                         i_stall;
    logic [1:0]                   o_action;
    logic [tcgp_pkg::CODE_W-1:0]  o_glyph_index;
    logic [tcgp_pkg::COORD_W-1:0] o_pos_x;
    logic [tcgp_pkg::COORD_W-1:0] o_pos_y;
    logic [tcgp_pkg::COORD_W-1:0] o_clear_width;
    logic [tcgp_pkg::COORD_W-1:0] o_clear_height;

    int mismatches;
    int results_due;
    int long_holds;

    text_cursor_glyph_placer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_char_code    (i_char_code),
        .i_target_column(i_target_column),
        .i_target_row   (i_target_row),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_action       (o_action),
        .o_glyph_index  (o_glyph_index),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_clear_width  (o_clear_width),
        .o_clear_height (o_clear_height)
    );

    tcgp_placement_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_opcode       (i_opcode),
        .i_char_code    (i_char_code),
        .i_target_column(i_target_column),
        .i_target_row   (i_target_row),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_action       (o_action),
        .i_glyph_index  (o_glyph_index),
        .i_pos_x        (o_pos_x),
        .i_pos_y        (o_pos_y),
        .i_clear_width  (o_clear_width),
        .i_clear_height (o_clear_height),
        .o_mismatches   (mismatches),
        .o_results_due  (results_due)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic send_item(input logic op, input logic [tcgp_pkg::CODE_W-1:0] code,
                             input logic [tcgp_pkg::COORD_W-1:0] col,
                             input logic [tcgp_pkg::COORD_W-1:0] row);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap  = (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(6, 20);
        @(negedge i_clk);
        for (int k = 0; k < gap; k++) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_char_code     <= code;
        i_target_column <= col;
        i_target_row    <= row;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input tcgp_pkg::t_reg_idx idx,
                             input logic [tcgp_pkg::COORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
    endtask

    task automatic load_layout(input logic [tcgp_pkg::COORD_W-1:0] col_org,
                               input logic [tcgp_pkg::COORD_W-1:0] col_last,
                               input logic [tcgp_pkg::COORD_W-1:0] row_org,
                               input logic [tcgp_pkg::COORD_W-1:0] row_last);
        write_reg(tcgp_pkg::REG_COLUMN_ORIGIN, col_org);
        write_reg(tcgp_pkg::REG_LAST_COLUMN, col_last);
        write_reg(tcgp_pkg::REG_ROW_ORIGIN, row_org);
        write_reg(tcgp_pkg::REG_LAST_ROW, row_last);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver back-pressure
    initial begin
        int stall_left;
        int open_left;
        int pick;
        int holds_seen;
        stall_left = 0;
        open_left  = 0;
        holds_seen = 0;
        i_stall    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_holds != holds_seen) begin
                holds_seen = long_holds;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (open_left > 0) begin
                i_stall <= 1'b0;
                open_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 35) open_left = $urandom_range(4, 40);
                else if (pick < 90) stall_left = $urandom_range(1, 3);
                else stall_left = $urandom_range(8, 25);
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction at all
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        logic [tcgp_pkg::CODE_W-1:0] probe_codes[$];
        int sent;
        int run;
        int pick;
        logic [tcgp_pkg::COORD_W-1:0] col;
        logic [tcgp_pkg::COORD_W-1:0] row;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = tcgp_pkg::REG_COLUMN_ORIGIN;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_opcode        = tcgp_pkg::OP_PUT_CHAR;
        i_char_code     = '0;
        i_target_column = '0;
        i_target_row    = '0;
        long_holds      = 0;
        probe_codes = '{8'd65, 8'd0, 8'd31, tcgp_pkg::CODE_NEWLINE, 8'd122,
                        tcgp_pkg::CODE_FORM_FEED, 8'd32,
                        8'd123, 8'd205, 8'd206, 8'd211, 8'd212, 8'd215, 8'd216, 8'd217,
                        8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223, 8'd224, 8'd255};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_codes[k]) begin
            send_item(tcgp_pkg::OP_PUT_CHAR, probe_codes[k], 8'($urandom), 8'($urandom));
        end
        send_item(tcgp_pkg::OP_MOVE, 8'd0, 8'd0, 8'd0);
        send_item(tcgp_pkg::OP_MOVE, 8'd0, 8'd255, 8'd255);
        send_item(tcgp_pkg::OP_PUT_CHAR, tcgp_pkg::CODE_FORM_FEED, 8'($urandom), 8'($urandom));

        for (int phase = 0; phase < 7; phase++) begin
            unique case (phase)
                1: load_layout(tcgp_pkg::RST_COLUMN_ORIGIN, tcgp_pkg::RST_LAST_COLUMN,
                               tcgp_pkg::RST_ROW_ORIGIN, tcgp_pkg::RST_LAST_ROW);
                2: load_layout(8'd0, 8'd0, 8'd0, 8'd0);
                3: begin
                    load_layout(8'd255, 8'd255, 8'd255, 8'd255);
                    long_holds++;
                end
                5: load_layout(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                4, 6: load_layout(8'($urandom), 8'($urandom_range(0, 4)),
                                  8'($urandom), 8'($urandom_range(0, 3)));
                default: ;
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // a run of printable text, then a newline, form feed, cursor move, control code or random item
                run = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(30, 70);
                repeat (run) begin
                    send_item(tcgp_pkg::OP_PUT_CHAR, 8'($urandom_range(32, 255)),
                              8'($urandom), 8'($urandom));
                    sent++;
                end
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_item(tcgp_pkg::OP_PUT_CHAR, tcgp_pkg::CODE_NEWLINE,
                              8'($urandom), 8'($urandom));
                    sent++;
                end else if (pick < 65) begin
                    send_item(tcgp_pkg::OP_PUT_CHAR, tcgp_pkg::CODE_FORM_FEED,
                              8'($urandom), 8'($urandom));
                    sent++;
                end else if (pick < 85) begin
                    col = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 45)) : 8'($urandom);
                    row = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 20)) : 8'($urandom);
                    send_item(tcgp_pkg::OP_MOVE, 8'($urandom), col, row);
                    sent++;
                end else if (pick < 95) begin
                    send_item(tcgp_pkg::OP_PUT_CHAR, 8'($urandom_range(0, 31)),
                              8'($urandom), 8'($urandom));
                end else begin
                    send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                              8'($urandom));
                    sent++;
                end
            end
            drain;
        end

        repeat (8) @(negedge i_clk);
        if (results_due != 0) begin
            $display("%0t: %0d results never arrived", $time, results_due);
        end
        if (mismatches == 0 && results_due == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
